@@ design/sirm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse index range map - shared definitions
// Sizes, request and status codes, table entry, result layout and FSM states.
// ----------------------------------------------------------------------------
package sirm_pkg;

  localparam int MAX_RANGES  = 16;
  localparam int INDEX_BITS  = 16;
  localparam int ADDR_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W       = $clog2(MAX_RANGES + 1);
  localparam int SPAN_W      = INDEX_BITS + 1;
  localparam int REQ_W       = 3;
  localparam int STAT_W      = 2;
  localparam int RESULT_W    = 4 * INDEX_BITS + SPAN_W + 4;
  localparam int IN_TDATA_W  = ((3 * INDEX_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef logic [INDEX_BITS-1:0] idx_t;

  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INDEX    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POSITION = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SPAN     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    idx_t start;
    idx_t stop;
    idx_t offset;
  } entry_t;

  // first member sits in the top bits
  typedef struct packed {
    logic [SPAN_W-1:0] span_count;
    logic              contiguous;
    logic              has_previous;
    idx_t              previous_valid;
    logic              has_next;
    idx_t              next_valid;
    idx_t              mapped_index;
    idx_t              dense_position;
    logic              contains;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_APPEND,
    S_SEARCH,
    S_PROBE,
    S_PREV,
    S_DONE
  } state_t;

endpackage

@@ design/sparse_index_range_map.sv @@
// ----------------------------------------------------------------------------
// Sparse index range map
// Sorted table of disjoint index ranges with append, clear and binary-search
// lookups (index, dense position, span).
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser
//  in_     | in  | index_a, index_b, position              | req_type
//  out_    | out | contains .. span_count (see port notes) | status
//
//  One request at a time; in_tready is high only when the sequencer is idle.
//  Queries search the table through its single read port, one probe a cycle,
//  P = clog2(MAX_RANGES + 1) probes at most (5 here); span runs two searches.
//  A finished result waits in the output register while the next request runs.
//  Sync active-low reset empties the table.
// ----------------------------------------------------------------------------
module sparse_index_range_map import sirm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // index_a, index_b, position
  input  logic [REQ_W-1:0]       in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // contains, dense_position,
                                             // mapped_index, next_valid,
                                             // has_next, previous_valid,
                                             // has_previous, contiguous,
                                             // span_count, zero pad
  output logic [STAT_W-1:0]      out_tuser   // status
);

  state_t            state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  idx_t              a_r, a_nxt, b_r, b_nxt, p_r, p_nxt;
  idx_t              key_r, key_nxt;
  logic              pmode_r, pmode_nxt;
  logic              phase_r, phase_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt, sel_r, sel_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  idx_t              pa_r, pa_nxt;
  result_t           res_r, res_nxt, out_res_r;
  logic [STAT_W-1:0] stat_r, stat_nxt, out_stat_r;
  logic              out_valid_r;

  entry_t            mem [MAX_RANGES];
  entry_t            rd_data_r;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  entry_t            wr_data;

  logic              in_beat, out_free, out_load;
  idx_t              probe_val;
  logic              probe_lt;
  logic [CNT_W-1:0]  lo_c, hi_c, gap_c, mid_c, last_c;
  logic              search_go, hit_c, a_ge_start, span_ok;
  logic              merge_c, table_full;
  idx_t              next_pos, pb_c, pdiff_c;

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = (state_r == S_DONE) && out_free;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, out_res_r};

  // shared compare unit of the search
  assign probe_val = pmode_r ? (rd_data_r.stop - rd_data_r.offset) : rd_data_r.stop;
  assign probe_lt  = probe_val < key_r;

  always_comb begin
    lo_c = lo_r;
    hi_c = hi_r;
    if (pend_r) begin
      if (probe_lt) begin
        lo_c = CNT_W'(mid_r) + CNT_W'(1);
      end else begin
        hi_c = CNT_W'(mid_r);
      end
    end
  end

  assign gap_c      = hi_c - lo_c;
  assign mid_c      = lo_c + (gap_c >> 1);
  assign search_go  = lo_c < hi_c;
  assign hit_c      = lo_c != count_r;
  assign last_c     = count_r - CNT_W'(1);
  assign a_ge_start = a_r >= rd_data_r.start;
  assign span_ok    = a_ge_start && (a_r <= b_r);
  assign merge_c    = {1'b0, a_r} == ({1'b0, rd_data_r.stop} + SPAN_W'(1));
  assign table_full = count_r == CNT_W'(MAX_RANGES);
  assign next_pos   = rd_data_r.stop - rd_data_r.offset + INDEX_BITS'(1);
  assign pb_c       = b_r - rd_data_r.offset;
  assign pdiff_c    = pb_c - pa_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_beat) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (req_r)
          REQ_APPEND:   state_nxt = S_APPEND;
          REQ_INDEX:    state_nxt = (count_r == '0) ? S_DONE : S_SEARCH;
          REQ_POSITION: state_nxt = S_SEARCH;
          REQ_SPAN:     state_nxt = S_SEARCH;
          default:      state_nxt = S_DONE;
        endcase
      end
      S_APPEND: state_nxt = S_DONE;
      S_SEARCH: begin
        if (search_go) begin
          state_nxt = S_SEARCH;
        end else if (hit_c) begin
          state_nxt = S_PROBE;
        end else if (req_r == REQ_INDEX) begin
          state_nxt = S_PREV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PROBE: begin
        state_nxt = S_DONE;
        if (req_r == REQ_INDEX && !a_ge_start && sel_r != '0) state_nxt = S_PREV;
        if (req_r == REQ_SPAN && !phase_r && span_ok) state_nxt = S_SEARCH;
      end
      S_PREV: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and table access
  always_comb begin
    req_nxt   = req_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    p_nxt     = p_r;
    key_nxt   = key_r;
    pmode_nxt = pmode_r;
    phase_nxt = phase_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    sel_nxt   = sel_r;
    mid_nxt   = mid_r;
    pend_nxt  = pend_r;
    count_nxt = count_r;
    pa_nxt    = pa_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          req_nxt = in_tuser;
          a_nxt   = in_tdata[INDEX_BITS-1:0];
          b_nxt   = in_tdata[2*INDEX_BITS-1:INDEX_BITS];
          p_nxt   = in_tdata[3*INDEX_BITS-1:2*INDEX_BITS];
        end
      end
      S_DISPATCH: begin
        res_nxt   = '0;
        stat_nxt  = ST_MISS;
        phase_nxt = 1'b0;
        lo_nxt    = '0;
        hi_nxt    = count_r;
        pend_nxt  = 1'b0;
        pmode_nxt = (req_r == REQ_POSITION);
        key_nxt   = (req_r == REQ_POSITION) ? p_r : a_r;
        case (req_r)
          REQ_APPEND: begin
            rd_en   = 1'b1;
            rd_addr = last_c[ADDR_W-1:0];
          end
          REQ_CLEAR: begin
            count_nxt = '0;
            stat_nxt  = ST_OK;
          end
          default: ;
        endcase
      end
      S_APPEND: begin
        if (a_r > b_r) begin
          stat_nxt = ST_ORDER;
        end else if (count_r == '0) begin
          wr_en     = 1'b1;
          wr_data   = '{start: a_r, stop: b_r, offset: a_r};
          count_nxt = CNT_W'(1);
          stat_nxt  = ST_OK;
        end else if (a_r <= rd_data_r.stop) begin
          stat_nxt = ST_ORDER;
        end else if (merge_c) begin
          wr_en        = 1'b1;
          wr_addr      = last_c[ADDR_W-1:0];
          wr_data.stop = b_r;
          stat_nxt     = ST_OK;
        end else if (table_full) begin
          stat_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = count_r[ADDR_W-1:0];
          wr_data   = '{start: a_r, stop: b_r, offset: a_r - next_pos};
          count_nxt = count_r + CNT_W'(1);
          stat_nxt  = ST_OK;
        end
      end
      S_SEARCH: begin
        lo_nxt   = lo_c;
        hi_nxt   = hi_c;
        mid_nxt  = mid_c[ADDR_W-1:0];
        pend_nxt = search_go;
        sel_nxt  = lo_c;
        if (search_go) begin
          rd_en   = 1'b1;
          rd_addr = mid_c[ADDR_W-1:0];
        end else if (hit_c) begin
          rd_en   = 1'b1;
          rd_addr = lo_c[ADDR_W-1:0];
        end else if (req_r == REQ_INDEX) begin
          rd_en   = 1'b1;
          rd_addr = last_c[ADDR_W-1:0];
        end
      end
      S_PROBE: begin
        case (req_r)
          REQ_INDEX: begin
            if (a_ge_start) begin
              res_nxt.contains       = 1'b1;
              res_nxt.dense_position = a_r - rd_data_r.offset;
              res_nxt.next_valid     = a_r;
              res_nxt.has_next       = 1'b1;
              res_nxt.previous_valid = a_r;
              res_nxt.has_previous   = 1'b1;
              stat_nxt               = ST_OK;
            end else begin
              res_nxt.next_valid = rd_data_r.start;
              res_nxt.has_next   = 1'b1;
              rd_en              = 1'b1;
              rd_addr            = ADDR_W'(sel_r - CNT_W'(1));
            end
          end
          REQ_POSITION: begin
            res_nxt.mapped_index = p_r + rd_data_r.offset;
            stat_nxt             = ST_OK;
          end
          REQ_SPAN: begin
            if (!phase_r) begin
              res_nxt.contiguous = span_ok && (b_r <= rd_data_r.stop);
              pa_nxt             = a_r - rd_data_r.offset;
              phase_nxt          = 1'b1;
              key_nxt            = b_r;
              lo_nxt             = '0;
              hi_nxt             = count_r;
              pend_nxt           = 1'b0;
            end else if (b_r >= rd_data_r.start) begin
              res_nxt.span_count = {1'b0, pdiff_c} + SPAN_W'(1);
              stat_nxt           = ST_OK;
            end
          end
          default: ;
        endcase
      end
      S_PREV: begin
        res_nxt.previous_valid = rd_data_r.stop;
        res_nxt.has_previous   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    p_r     <= p_nxt;
    key_r   <= key_nxt;
    pmode_r <= pmode_nxt;
    phase_r <= phase_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    sel_r   <= sel_nxt;
    mid_r   <= mid_nxt;
    pend_r  <= pend_nxt;
    pa_r    <= pa_nxt;
    res_r   <= res_nxt;
    stat_r  <= stat_nxt;
    if (out_load) begin
      out_res_r  <= res_r;
      out_stat_r <= stat_r;
    end
  end

  // range table
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

endmodule

@@ design/sirm_checker.sv @@
// ----------------------------------------------------------------------------
// Sparse index range map - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module sirm_checker import sirm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]      out_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

  // failed requests carry no membership and no span
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |->
      !out_tdata[0] && out_tdata[RESULT_W-1:RESULT_W-SPAN_W] == '0)
    else $error("failed request with membership or span");

  // a member is its own neighbour on both sides
  a_contains: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      out_tdata[3*INDEX_BITS+1] && out_tdata[4*INDEX_BITS+2] && out_tuser == ST_OK)
    else $error("member without neighbour flags");

endmodule

bind sparse_index_range_map sirm_checker u_sirm_checker (.*);

@@ tb/sparse_index_range_map_test.sv @@
// ----------------------------------------------------------------------------
// Sparse index range map - testbench
// Streams append, clear, index, position and span requests into the block,
// predicts every answer from a local copy of the range table and checks each
// result beat field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module sparse_index_range_map_test;
  import sirm_pkg::*;

  localparam int ITEMS      = 1150;
  localparam int QUIET_TAIL = 150;
  localparam int IDLE_LIMIT = 2000;

  localparam logic [REQ_W-1:0] REQ_UNUSED_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI  = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    result_t           fields;
  } answer_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // index_a, index_b, position
  logic [REQ_W-1:0]       in_tuser;   // req_type
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // contains, dense_position, mapped_index,
                                      // next_valid, has_next, previous_valid,
                                      // has_previous, contiguous, span_count
  logic [STAT_W-1:0]      out_tuser;  // status

  idx_t    tbl_start [MAX_RANGES];
  idx_t    tbl_stop  [MAX_RANGES];
  idx_t    tbl_off   [MAX_RANGES];
  int      tbl_count;
  answer_t answers [$];

  bit calm;
  int stall;
  int idle_cycles;
  int mismatches;
  int n_sent, n_checked, n_hits, n_merged, n_full;

  sparse_index_range_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic idx_t rand16();
    return idx_t'($urandom_range(0, 65535));
  endfunction

  // first range whose stop is not below idx
  function automatic int first_stop_not_below(idx_t idx);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_stop[mid] < idx) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit dense_of(idx_t idx, output idx_t pos);
    int r;
    pos = '0;
    r = first_stop_not_below(idx);
    if (r >= tbl_count || idx < tbl_start[r]) return 1'b0;
    pos = idx - tbl_off[r];
    return 1'b1;
  endfunction

  function automatic answer_t predict_answer(logic [REQ_W-1:0] req, idx_t a, idx_t b,
                                             idx_t p);
    answer_t ans;
    int      r, last, lo, hi, mid;
    idx_t    lstop, next_pos, pa, pb;
    bit      ina, inb;
    ans = '0;
    ans.status = ST_MISS;
    case (req)
      REQ_APPEND: begin
        if (a > b) begin
          ans.status = ST_ORDER;
        end else if (tbl_count == 0) begin
          tbl_start[0] = a;
          tbl_stop[0]  = b;
          tbl_off[0]   = a;
          tbl_count    = 1;
          ans.status   = ST_OK;
        end else begin
          last  = tbl_count - 1;
          lstop = tbl_stop[last];
          if (a <= lstop) begin
            ans.status = ST_ORDER;
          end else if (a == lstop + 16'd1) begin
            tbl_stop[last] = b;
            ans.status = ST_OK;
            n_merged++;
          end else if (tbl_count >= MAX_RANGES) begin
            ans.status = ST_FULL;
            n_full++;
          end else begin
            next_pos = lstop - tbl_off[last] + 16'd1;
            tbl_start[tbl_count] = a;
            tbl_stop[tbl_count]  = b;
            tbl_off[tbl_count]   = a - next_pos;
            tbl_count++;
            ans.status = ST_OK;
          end
        end
      end
      REQ_INDEX: begin
        if (tbl_count != 0) begin
          r = first_stop_not_below(a);
          if (r < tbl_count) begin
            if (a >= tbl_start[r]) begin
              ans.fields.contains       = 1'b1;
              ans.fields.dense_position = a - tbl_off[r];
              ans.fields.next_valid     = a;
              ans.fields.has_next       = 1'b1;
              ans.fields.previous_valid = a;
              ans.fields.has_previous   = 1'b1;
              n_hits++;
            end else begin
              ans.fields.next_valid = tbl_start[r];
              ans.fields.has_next   = 1'b1;
              if (r > 0) begin
                ans.fields.previous_valid = tbl_stop[r-1];
                ans.fields.has_previous   = 1'b1;
              end
            end
          end else begin
            ans.fields.previous_valid = tbl_stop[tbl_count-1];
            ans.fields.has_previous   = 1'b1;
          end
          ans.status = ans.fields.contains ? ST_OK : ST_MISS;
        end
      end
      REQ_POSITION: begin
        lo = 0;
        hi = tbl_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (idx_t'(tbl_stop[mid] - tbl_off[mid]) < p) lo = mid + 1;
          else hi = mid;
        end
        if (lo < tbl_count) begin
          ans.fields.mapped_index = p + tbl_off[lo];
          ans.status = ST_OK;
        end
      end
      REQ_SPAN: begin
        ina = dense_of(a, pa);
        inb = dense_of(b, pb);
        if (tbl_count != 0 && a <= b) begin
          r = first_stop_not_below(a);
          if (r < tbl_count && a >= tbl_start[r] && b <= tbl_stop[r])
            ans.fields.contiguous = 1'b1;
        end
        if (ina && inb && a <= b) begin
          ans.fields.span_count = {1'b0, pb} - {1'b0, pa} + 17'd1;
          ans.status = ST_OK;
        end
      end
      REQ_CLEAR: begin
        tbl_count  = 0;
        ans.status = ST_OK;
      end
      default: ans.status = ST_MISS;
    endcase
    return ans;
  endfunction

  task automatic send_request(logic [REQ_W-1:0] req, idx_t a, idx_t b, idx_t p);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = '0;
    in_tdata[3*INDEX_BITS-1:0] = {p, b, a};
    do @(posedge clk); while (!in_tready);
    answers.push_back(predict_answer(req, a, b, p));
    n_sent++;
  endtask

  task automatic wait_for_answers();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (answers.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, logic [SPAN_W-1:0] want, logic [SPAN_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // result side: random stall bursts until the quiet tail
  always @(negedge clk) begin
    if (stall > 0) begin
      stall--;
      out_tready = 1'b0;
    end else if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(0, 10);
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[RESULT_W-1:0];
      if (answers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, got status %0h data %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = answers.pop_front();
        n_checked++;
        compare_field("status", want.status, out_tuser);
        compare_field("contains", want.fields.contains, got.contains);
        compare_field("dense_position", want.fields.dense_position, got.dense_position);
        compare_field("mapped_index", want.fields.mapped_index, got.mapped_index);
        compare_field("next_valid", want.fields.next_valid, got.next_valid);
        compare_field("has_next", want.fields.has_next, got.has_next);
        compare_field("previous_valid", want.fields.previous_valid, got.previous_valid);
        compare_field("has_previous", want.fields.has_previous, got.has_previous);
        compare_field("contiguous", want.fields.contiguous, got.contiguous);
        compare_field("span_count", want.fields.span_count, got.span_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_request(REQ_INDEX, 16'h0000, rand16(), rand16());
    send_request(REQ_INDEX, 16'hffff, rand16(), rand16());
    send_request(REQ_POSITION, rand16(), rand16(), 16'h0000);
    send_request(REQ_SPAN, 16'h0000, 16'h0000, rand16());
    send_request(REQ_UNUSED_LO, rand16(), rand16(), rand16());
    send_request(REQ_UNUSED_MID, rand16(), rand16(), rand16());
    send_request(REQ_UNUSED_HI, rand16(), rand16(), rand16());
    send_request(REQ_CLEAR, rand16(), rand16(), rand16());
  endtask

  task automatic test_append_and_lookup();
    send_request(REQ_APPEND, 16'd5, 16'd3, 16'd0);     // start above stop
    send_request(REQ_APPEND, 16'd10, 16'd20, 16'd0);
    send_request(REQ_APPEND, 16'd15, 16'd30, 16'd0);   // overlaps
    send_request(REQ_APPEND, 16'd20, 16'd25, 16'd0);   // starts on last stop
    send_request(REQ_APPEND, 16'd21, 16'd21, 16'd0);   // point, merges
    send_request(REQ_APPEND, 16'd40, 16'd40, 16'd0);   // point, new range
    send_request(REQ_APPEND, 16'd42, 16'd100, 16'd0);
    send_request(REQ_INDEX, 16'd9, 16'd0, 16'd0);
    send_request(REQ_INDEX, 16'd41, 16'd0, 16'd0);
    send_request(REQ_INDEX, 16'd200, 16'd0, 16'd0);
    send_request(REQ_POSITION, 16'd0, 16'd0, 16'd12);
    send_request(REQ_POSITION, 16'd0, 16'd0, 16'd72);
    send_request(REQ_SPAN, 16'd10, 16'd21, 16'd0);
    send_request(REQ_SPAN, 16'd10, 16'd40, 16'd0);
    send_request(REQ_SPAN, 16'd21, 16'd10, 16'd0);
    send_request(REQ_SPAN, 16'd30, 16'd40, 16'd0);
  endtask

  task automatic test_index_extremes();
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0);
    send_request(REQ_APPEND, 16'h0000, 16'hffff, 16'hffff);
    send_request(REQ_SPAN, 16'h0000, 16'hffff, 16'd0);
    send_request(REQ_POSITION, 16'd0, 16'd0, 16'hffff);
    send_request(REQ_APPEND, 16'hffff, 16'hffff, 16'd0);
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0);
    send_request(REQ_APPEND, 16'hffff, 16'hffff, 16'd0);
    send_request(REQ_INDEX, 16'h0000, 16'd0, 16'd0);
  endtask

  function automatic idx_t near_index();
    int r;
    r = (tbl_count == 0) ? 0 : $urandom_range(0, tbl_count - 1);
    if (tbl_count == 0 || $urandom_range(0, 5) == 0) return rand16();
    case ($urandom_range(0, 4))
      0:       return tbl_start[r] - 16'd1;
      1:       return tbl_start[r];
      2:       return tbl_stop[r];
      3:       return tbl_stop[r] + 16'd1;
      default: return idx_t'($urandom_range(tbl_start[r], tbl_stop[r]));
    endcase
  endfunction

  task automatic test_random_tables();
    int   scale, last_pos, a_i, b_i;
    bit   paused;
    idx_t a, b, p;
    paused = 1'b0;
    while (n_sent < ITEMS) begin
      if (n_sent >= ITEMS - QUIET_TAIL) calm = 1'b1;
      if (!paused && n_sent >= ITEMS / 2) begin
        wait_for_answers();
        paused = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) send_request(REQ_CLEAR, rand16(), rand16(), rand16());
      case ($urandom_range(0, 2))
        0:       scale = 15;
        1:       scale = 300;
        default: scale = 3000;
      endcase
      repeat ($urandom_range(1, 18)) begin
        if (tbl_count == 0) a_i = $urandom_range(0, scale);
        else if ($urandom_range(0, 19) == 0)
          a_i = int'(tbl_stop[tbl_count-1]) - $urandom_range(0, scale);
        else if ($urandom_range(0, 5) == 0) a_i = tbl_stop[tbl_count-1] + 1;
        else a_i = tbl_stop[tbl_count-1] + 1 + $urandom_range(1, scale);
        if (a_i < 0) a_i = 0;
        if (a_i > 65535) a_i = $urandom_range(0, 65535);
        b_i = a_i + $urandom_range(0, scale / 2);
        if (b_i > 65535) b_i = 65535;
        if ($urandom_range(0, 19) == 0 && a_i > 0) b_i = $urandom_range(0, a_i - 1);
        send_request(REQ_APPEND, idx_t'(a_i), idx_t'(b_i), rand16());
      end
      repeat ($urandom_range(5, 30)) begin
        a = near_index();
        b = ($urandom_range(0, 3) == 0) ? a : near_index();
        last_pos = (tbl_count == 0) ? 0 : tbl_stop[tbl_count-1] - tbl_off[tbl_count-1];
        p = ($urandom_range(0, 4) == 0) ? rand16() :
            idx_t'((last_pos + 2 > 65535) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, last_pos + 2));
        case ($urandom_range(0, 9))
          0:          send_request(REQ_W'($urandom_range(0, 7)), rand16(), rand16(), rand16());
          1, 2, 3, 4: send_request(REQ_INDEX, a, rand16(), rand16());
          5, 6:       send_request(REQ_POSITION, rand16(), rand16(), p);
          default:    send_request(REQ_SPAN, a, b, rand16());
        endcase
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_APPEND;
    out_tready = 1'b0;
    calm       = 1'b0;
    tbl_count  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_append_and_lookup();
    test_index_extremes();
    test_random_tables();

    wait_for_answers();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests, checked %0d results (%0d index hits, %0d merges,",
             n_sent, n_checked, n_hits, n_merged);
    $display("%0d full-table rejects) under random stalls on both channels.", n_full);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sirm_pkg.sv
design/sparse_index_range_map.sv
design/sirm_checker.sv
tb/sparse_index_range_map_test.sv
